### sv/rbfl_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and constants of the RBF linear kernel evaluator.
package rbfl_pkg;

	localparam int DEFAULT_MAX_CENTERS = 64;
	localparam int ROOT_STEPS = 34;
	localparam int REG_INDEX_W = 3;
	localparam int REG_DATA_W = 32;

	localparam logic [REG_INDEX_W-1:0] REG_NUM_CENTERS = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_POLY_CONST = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_POLY_X = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_POLY_Y = 3'd3;
	localparam logic [REG_INDEX_W-1:0] REG_POLY_Z = 3'd4;

	localparam logic ACTION_LOAD = 1'b0;
	localparam logic ACTION_QUERY = 1'b1;

	typedef struct packed {
		logic action;
		logic [5:0] entry_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic signed [31:0] center_weight;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] estimate;
		logic saturated;
	} out_word_t;

	typedef enum logic [1:0] {
		MS_DIST,
		MS_X,
		MS_Y,
		MS_Z
	} mul_sel_t;

endpackage

### sv/rbfl_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
module rbfl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

### sv/rbfl_datapath.sv
`timescale 1ns / 1ps
// Datapath: center table, distance and root unit, shared multiplier, accumulator, output.
module rbfl_datapath #(
	parameter int MAX_CENTERS = rbfl_pkg::DEFAULT_MAX_CENTERS,
	localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1,
	localparam int CW = $clog2(MAX_CENTERS + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [rbfl_pkg::REG_INDEX_W-1:0] wr_index,
	input logic [rbfl_pkg::REG_DATA_W-1:0] wr_data,
	input rbfl_pkg::in_word_t in_data,
	input logic point_ld,
	input logic load_wr,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	input logic diff_en,
	input logic sq_en,
	input logic sum_en,
	input logic root_en,
	input logic mul_en,
	input rbfl_pkg::mul_sel_t mul_sel,
	input logic acc_clr,
	input logic acc_en,
	input logic out_ld,
	input logic out_stall,
	output logic [CW-1:0] n_eff,
	output logic out_full,
	output logic out_valid,
	output rbfl_pkg::out_word_t out_data
);
	import rbfl_pkg::*;

	logic [6:0] num_centers_q;
	logic signed [31:0] poly_const_q, poly_x_q, poly_y_q, poly_z_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [127:0] rd_data;
	logic signed [31:0] cx, cy, cz, cw;
	logic signed [33:0] dxs, dys, dzs;
	logic [32:0] dx_q, dy_q, dz_q;
	logic [65:0] sx_q, sy_q, sz_q;
	logic [67:0] rad_q;
	logic [37:0] rem_q;
	logic [33:0] root_q;
	logic [37:0] t_rem, trial;
	logic [33:0] op_a;
	logic [31:0] op_b;
	logic op_neg;
	logic [65:0] prod_q;
	logic neg_q;
	logic [50:0] rnd;
	logic signed [63:0] acc_q, total;
	logic out_valid_q;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_centers_q <= '0;
			poly_const_q <= '0;
			poly_x_q <= '0;
			poly_y_q <= '0;
			poly_z_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_NUM_CENTERS: num_centers_q <= wr_data[6:0];
				REG_POLY_CONST: poly_const_q <= wr_data;
				REG_POLY_X: poly_x_q <= wr_data;
				REG_POLY_Y: poly_y_q <= wr_data;
				REG_POLY_Z: poly_z_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(num_centers_q) > MAX_CENTERS) begin
			n_eff = CW'(MAX_CENTERS);
		end else begin
			n_eff = CW'(num_centers_q);
		end
	end

	rbfl_ram #(
		.WIDTH(128),
		.DEPTH(MAX_CENTERS)
	) u_table (
		.clk(clk),
		.we(load_wr),
		.waddr(AW'(in_data.entry_index)),
		.wdata({in_data.coord_x, in_data.coord_y, in_data.coord_z, in_data.center_weight}),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata_q(rd_data)
	);

	assign cx = rd_data[127:96];
	assign cy = rd_data[95:64];
	assign cz = rd_data[63:32];
	assign cw = rd_data[31:0];

	assign dxs = 34'(px_q) - 34'(cx);
	assign dys = 34'(py_q) - 34'(cy);
	assign dzs = 34'(pz_q) - 34'(cz);

	assign t_rem = {rem_q[35:0], rad_q[67:66]};
	assign trial = {2'b00, root_q, 2'b01};

	always_comb begin
		case (mul_sel)
			MS_DIST: begin
				op_a = root_q;
				op_b = mag32(cw);
				op_neg = cw[31];
			end
			MS_X: begin
				op_a = {2'b00, mag32(px_q)};
				op_b = mag32(poly_x_q);
				op_neg = px_q[31] ^ poly_x_q[31];
			end
			MS_Y: begin
				op_a = {2'b00, mag32(py_q)};
				op_b = mag32(poly_y_q);
				op_neg = py_q[31] ^ poly_y_q[31];
			end
			default: begin
				op_a = {2'b00, mag32(pz_q)};
				op_b = mag32(poly_z_q);
				op_neg = pz_q[31] ^ poly_z_q[31];
			end
		endcase
	end

	assign rnd = 51'((prod_q + 66'h8000) >> 16);
	assign total = acc_q + 64'(poly_const_q);

	always_ff @(posedge clk) begin
		if (point_ld) begin
			px_q <= in_data.coord_x;
			py_q <= in_data.coord_y;
			pz_q <= in_data.coord_z;
		end
		if (diff_en) begin
			dx_q <= dxs[33] ? 33'(-dxs) : 33'(dxs);
			dy_q <= dys[33] ? 33'(-dys) : 33'(dys);
			dz_q <= dzs[33] ? 33'(-dzs) : 33'(dzs);
		end
		if (sq_en) begin
			sx_q <= 66'(dx_q) * 66'(dx_q);
			sy_q <= 66'(dy_q) * 66'(dy_q);
			sz_q <= 66'(dz_q) * 66'(dz_q);
		end
		if (sum_en) begin
			rad_q <= 68'(sx_q) + 68'(sy_q) + 68'(sz_q);
			rem_q <= '0;
			root_q <= '0;
		end else if (root_en) begin
			rad_q <= {rad_q[65:0], 2'b00};
			if (t_rem >= trial) begin
				rem_q <= t_rem - trial;
				root_q <= {root_q[32:0], 1'b1};
			end else begin
				rem_q <= t_rem;
				root_q <= {root_q[32:0], 1'b0};
			end
		end
		if (mul_en) begin
			prod_q <= 66'(op_a) * 66'(op_b);
			neg_q <= op_neg;
		end
		if (acc_clr) begin
			acc_q <= '0;
		end else if (acc_en) begin
			if (neg_q) begin
				acc_q <= acc_q - $signed({13'b0, rnd});
			end else begin
				acc_q <= acc_q + $signed({13'b0, rnd});
			end
		end
		if (out_ld) begin
			if (total > 64'sh7FFF_FFFF) begin
				out_data.estimate <= 32'sh7FFF_FFFF;
				out_data.saturated <= 1'b1;
			end else if (total < -64'sh8000_0000) begin
				out_data.estimate <= 32'sh8000_0000;
				out_data.saturated <= 1'b1;
			end else begin
				out_data.estimate <= total[31:0];
				out_data.saturated <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_full = out_valid_q && out_stall;

endmodule

### sv/rbfl_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the table walk, square root steps, polynomial terms and result.
module rbfl_ctrl #(
	parameter int MAX_CENTERS = rbfl_pkg::DEFAULT_MAX_CENTERS,
	localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1,
	localparam int CW = $clog2(MAX_CENTERS + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_action,
	input logic [5:0] in_entry_index,
	input logic [CW-1:0] n_eff,
	input logic out_full,
	output logic in_stall,
	output logic point_ld,
	output logic load_wr,
	output logic rd_en,
	output logic [AW-1:0] rd_addr,
	output logic diff_en,
	output logic sq_en,
	output logic sum_en,
	output logic root_en,
	output logic mul_en,
	output rbfl_pkg::mul_sel_t mul_sel,
	output logic acc_clr,
	output logic acc_en,
	output logic out_ld
);
	import rbfl_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_DIFF,
		ST_SQ,
		ST_SUM,
		ST_ROOT,
		ST_MUL,
		ST_ACC,
		ST_PMUL,
		ST_PACC,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [CW-1:0] idx_q;
	logic [5:0] step_q;
	mul_sel_t term_q;
	logic accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		point_ld = accept && (in_action == ACTION_QUERY);
		acc_clr = point_ld;
		load_wr = accept && (in_action == ACTION_LOAD) && (32'(in_entry_index) < MAX_CENTERS);
		rd_en = (state_q == ST_READ);
		rd_addr = idx_q[AW-1:0];
		diff_en = (state_q == ST_DIFF);
		sq_en = (state_q == ST_SQ);
		sum_en = (state_q == ST_SUM);
		root_en = (state_q == ST_ROOT);
		mul_en = (state_q == ST_MUL) || (state_q == ST_PMUL);
		mul_sel = (state_q == ST_PMUL) ? term_q : MS_DIST;
		acc_en = (state_q == ST_ACC) || (state_q == ST_PACC);
		out_ld = (state_q == ST_FIN) && !out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			step_q <= '0;
			term_q <= MS_X;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (point_ld) begin
						idx_q <= '0;
						term_q <= MS_X;
						state_q <= (n_eff == '0) ? ST_PMUL : ST_READ;
					end
				end
				ST_READ: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_SUM;
				ST_SUM: begin
					step_q <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'(ROOT_STEPS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					idx_q <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 == n_eff) ? ST_PMUL : ST_READ;
				end
				ST_PMUL: state_q <= ST_PACC;
				ST_PACC: begin
					if (term_q == MS_Z) begin
						state_q <= ST_FIN;
					end else begin
						term_q <= mul_sel_t'(term_q + 2'd1);
						state_q <= ST_PMUL;
					end
				end
				ST_FIN: begin
					if (!out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/rbf_linear_kernel_evaluate_unit.sv
`timescale 1ns / 1ps
// Top level of the RBF linear kernel evaluator.
//
// The input channel (in_valid, in_stall, in_data) takes one word at a time. A load
// word writes one center and its weight into the table in the cycle it is accepted
// and gives no result; the block is ready again in the next cycle. A query word
// walks the first num_centers table entries, at most MAX_CENTERS. Each center goes
// through a table read, the coordinate differences, the squares, their sum, 34 square
// root steps of one bit each, the weight product and the accumulate. The three
// polynomial terms then each go through a product and an accumulate, and the final
// sum and clip follow. The result word then appears on the output channel (out_valid,
// out_stall, out_data), and the next word can be taken in the same cycle.
// The input is stalled while a query runs.
// A result held by out_stall sits in the output register; further load words are
// still taken, and the next query finishes its walk and waits to deliver.
// Configuration writes go through wr_en, wr_index and wr_data while idle; the user
// must keep to this, the block does not enforce it. Reset clears the configuration
// registers, out_valid and control state; table contents are undefined until loaded.
module rbf_linear_kernel_evaluate_unit #(
	parameter int MAX_CENTERS = rbfl_pkg::DEFAULT_MAX_CENTERS
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [rbfl_pkg::REG_INDEX_W-1:0] wr_index,
	input logic [rbfl_pkg::REG_DATA_W-1:0] wr_data,
	input logic in_valid,
	output logic in_stall,
	input rbfl_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rbfl_pkg::out_word_t out_data
);
	import rbfl_pkg::*;

	localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int CW = $clog2(MAX_CENTERS + 1);

	logic [CW-1:0] n_eff;
	logic out_full, point_ld, load_wr, rd_en, diff_en, sq_en, sum_en, root_en;
	logic mul_en, acc_clr, acc_en, out_ld;
	logic [AW-1:0] rd_addr;
	mul_sel_t mul_sel;

	rbfl_ctrl #(.MAX_CENTERS(MAX_CENTERS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_action(in_data.action),
		.in_entry_index(in_data.entry_index),
		.n_eff(n_eff),
		.out_full(out_full),
		.in_stall(in_stall),
		.point_ld(point_ld),
		.load_wr(load_wr),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.diff_en(diff_en),
		.sq_en(sq_en),
		.sum_en(sum_en),
		.root_en(root_en),
		.mul_en(mul_en),
		.mul_sel(mul_sel),
		.acc_clr(acc_clr),
		.acc_en(acc_en),
		.out_ld(out_ld)
	);

	rbfl_datapath #(.MAX_CENTERS(MAX_CENTERS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_data(in_data),
		.point_ld(point_ld),
		.load_wr(load_wr),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.diff_en(diff_en),
		.sq_en(sq_en),
		.sum_en(sum_en),
		.root_en(root_en),
		.mul_en(mul_en),
		.mul_sel(mul_sel),
		.acc_clr(acc_clr),
		.acc_en(acc_en),
		.out_ld(out_ld),
		.out_stall(out_stall),
		.n_eff(n_eff),
		.out_full(out_full),
		.out_valid(out_valid),
		.out_data(out_data)
	);

endmodule

### sv/rbfl_checker.sv
`timescale 1ns / 1ps
// Port level checker for the RBF linear kernel evaluator, bound to the top level.
module rbfl_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input rbfl_pkg::in_word_t in_data,
	input logic out_valid,
	input logic out_stall,
	input rbfl_pkg::out_word_t out_data
);
	import rbfl_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("Stalled result word changed or dropped.");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == ACTION_QUERY |=> in_stall)
		else $error("Input not stalled after a query word was taken.");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == ACTION_LOAD |=> !in_stall)
		else $error("Input stalled after a load word.");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !$past(in_stall) && !$past(out_valid) |-> !out_valid)
		else $error("Result word appeared without a query.");

endmodule

bind rbf_linear_kernel_evaluate_unit rbfl_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
